### hdl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// Free page allocator package
// Shared constants, codes and payload types of the free page list allocator.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int MAX_PAGES        = 1024;
  localparam int SMALL_PAGE_SHIFT = 12;
  localparam int LARGE_PAGE_SHIFT = 21;
  localparam int ADDR_BITS        = 39;

  localparam int IDX_BITS      = $clog2(MAX_PAGES);
  localparam int COUNT_BITS    = $clog2(MAX_PAGES + 1);
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = ADDR_BITS;

  localparam logic [ADDR_BITS-1:0] SMALL_LOW_MASK =
    ADDR_BITS'((64'd1 << SMALL_PAGE_SHIFT) - 64'd1);
  localparam logic [ADDR_BITS-1:0] LARGE_LOW_MASK =
    ADDR_BITS'((64'd1 << LARGE_PAGE_SHIFT) - 64'd1);

  // Operation codes.
  localparam logic [1:0] FUNC_GET  = 2'd0;
  localparam logic [1:0] FUNC_PUT  = 2'd1;
  localparam logic [1:0] FUNC_INIT = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_SMALL_BASE  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SMALL_PAGES = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LARGE_BASE  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_LARGE_PAGES = 2'd3;

  typedef struct packed {
    logic [1:0]           func;
    logic                 page_class;
    logic [ADDR_BITS-1:0] free_addr;
    logic                 clear_request;
  } in_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0]  granted_addr;
    logic [1:0]            status;
    logic [COUNT_BITS-1:0] free_count;
    logic                  zero_fill;
  } out_t;

  // Region of the selected class: aligned base and clamped page count.
  typedef struct packed {
    logic [ADDR_BITS-1:0]  base;
    logic [COUNT_BITS-1:0] pages;
  } region_t;

  typedef struct packed {
    logic [IDX_BITS-1:0]   head;
    logic [IDX_BITS-1:0]   tail;
    logic [COUNT_BITS-1:0] count;
  } list_t;

  function automatic logic [ADDR_BITS-1:0] low_mask(input logic page_class);
    return page_class ? LARGE_LOW_MASK : SMALL_LOW_MASK;
  endfunction

endpackage

### hdl/fifo_free_page_list_allocator_unit.sv
// ----------------------------------------------------------------------------
// Free page list allocator
// Two FIFO free lists of pages (small pages and megapages) kept as linked
// next-pointer tables in one RAM, with head, tail and count per list.
// ----------------------------------------------------------------------------
// Each accepted word gives exactly one result word. One word is handled at a
// time, and the pace is set by the single next-pointer RAM, which has one
// write port and a registered read: a get reads the head pointer, then
// updates the head; an accepted put links the old tail (or sets the head of
// an empty list), then terminates the new tail; an init of a region writes
// the RAM once per page. A new word is taken while the previous result still
// waits in the output register. The next-pointer entries are undefined after
// reset and are not cleared; an init or a put writes every entry that a later
// get can reach.
module fifo_free_page_list_allocator_unit
  import fpa_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_t                      in_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_t                     out_item
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LINK = 2'd2;
  localparam logic [1:0] S_INIT = 2'd3;

  logic [1:0]          state;
  logic [1:0]          state_next;
  in_t                 item;
  list_t               small_list;
  list_t               large_list;
  list_t               cur;
  list_t               list_next;
  logic                list_we;
  logic [IDX_BITS-1:0] lidx;
  logic [IDX_BITS-1:0] lidx_next;
  logic [IDX_BITS-1:0] ptr;
  logic [IDX_BITS-1:0] ptr_next;
  region_t             region;

  logic                ram_we;
  logic [IDX_BITS:0]   ram_waddr;
  logic [IDX_BITS-1:0] ram_wdata;
  logic                ram_re;
  logic [IDX_BITS:0]   ram_raddr;
  logic [IDX_BITS-1:0] ram_rdata;

  logic                 accept;
  logic                 out_free;
  logic                 finish;
  out_t                 res;
  logic [ADDR_BITS:0]   diff;
  logic [ADDR_BITS-1:0] put_span;
  logic [IDX_BITS-1:0]  put_idx;
  logic                 put_ok;
  logic [ADDR_BITS-1:0] head_offset;
  logic                 init_last;

  fpa_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .page_class (item.page_class),
    .region     (region)
  );

  fpa_ram #(
    .ADDR_W (IDX_BITS + 1),
    .DATA_W (IDX_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // The head pointer of the addressed list is looked up as the word is taken.
  assign ram_re    = accept;
  assign ram_raddr = {in_item.page_class,
                      in_item.page_class ? large_list.head : small_list.head};

  always_comb begin
    cur = item.page_class ? large_list : small_list;

    // Put check: aligned, at or above the base, inside the region, list not full.
    diff     = {1'b0, item.free_addr} - {1'b0, region.base};
    put_span = item.page_class ? (diff[ADDR_BITS-1:0] >> LARGE_PAGE_SHIFT)
                               : (diff[ADDR_BITS-1:0] >> SMALL_PAGE_SHIFT);
    put_idx  = put_span[IDX_BITS-1:0];
    put_ok   = ((item.free_addr & low_mask(item.page_class)) == '0) &&
               !diff[ADDR_BITS] &&
               (put_span < ADDR_BITS'(region.pages)) &&
               (cur.count < COUNT_BITS'(MAX_PAGES));

    head_offset = item.page_class ? (ADDR_BITS'(cur.head) << LARGE_PAGE_SHIFT)
                                  : (ADDR_BITS'(cur.head) << SMALL_PAGE_SHIFT);
    init_last   = ({1'b0, ptr} == (region.pages - COUNT_BITS'(1)));

    state_next = state;
    list_next  = cur;
    list_we    = 1'b0;
    lidx_next  = lidx;
    ptr_next   = ptr;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    finish     = 1'b0;
    res        = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (item.func)
          FUNC_GET: begin
            if (out_free) begin
              finish     = 1'b1;
              state_next = S_IDLE;
              if (cur.count == '0) begin
                res.status = ST_EMPTY;
              end else begin
                list_next.head    = ram_rdata;
                list_next.count   = cur.count - COUNT_BITS'(1);
                list_we           = 1'b1;
                res.granted_addr  = region.base + head_offset;
                res.zero_fill     = item.clear_request;
              end
            end
          end
          FUNC_PUT: begin
            if (!put_ok) begin
              if (out_free) begin
                finish     = 1'b1;
                res.status = ST_BAD;
                state_next = S_IDLE;
              end
            end else begin
              lidx_next = put_idx;
              if (cur.count != '0) begin
                ram_we    = 1'b1;
                ram_waddr = {item.page_class, cur.tail};
                ram_wdata = put_idx;
              end else begin
                list_next.head = put_idx;
                list_we        = 1'b1;
              end
              state_next = S_LINK;
            end
          end
          FUNC_INIT: begin
            list_next = '0;
            list_we   = 1'b1;
            ptr_next  = '0;
            if (region.pages == '0) begin
              if (out_free) begin
                finish     = 1'b1;
                state_next = S_IDLE;
              end
            end else begin
              state_next = S_INIT;
            end
          end
          default: begin
            if (out_free) begin
              finish     = 1'b1;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_LINK: begin
        if (out_free) begin
          // The new tail ends the chain; written last so a duplicate put ends here.
          ram_we          = 1'b1;
          ram_waddr       = {item.page_class, lidx};
          ram_wdata       = '0;
          list_next.tail  = lidx;
          list_next.count = cur.count + COUNT_BITS'(1);
          list_we         = 1'b1;
          finish          = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_INIT: begin
        if (!init_last || out_free) begin
          ram_we    = 1'b1;
          ram_waddr = {item.page_class, ptr};
          ram_wdata = init_last ? '0 : ptr + IDX_BITS'(1);
          ptr_next  = ptr + IDX_BITS'(1);
          if (init_last) begin
            list_next.tail  = ptr;
            list_next.count = region.pages;
            list_we         = 1'b1;
            finish          = 1'b1;
            state_next      = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    res.free_count = list_next.count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      small_list <= '0;
      large_list <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (list_we) begin
        if (item.page_class) begin
          large_list <= list_next;
        end else begin
          small_list <= list_next;
        end
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_item;
    end
    lidx <= lidx_next;
    ptr  <= ptr_next;
    if (finish) begin
      out_item <= res;
    end
  end

endmodule

### hdl/fpa_ram.sv
// ----------------------------------------------------------------------------
// Free page allocator next-pointer RAM
// Simple dual-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module fpa_ram #(
  parameter int ADDR_W = 11,
  parameter int DATA_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/fpa_cfg.sv
// ----------------------------------------------------------------------------
// Free page allocator configuration registers
// Holds the region registers and presents the region of the selected class.
// ----------------------------------------------------------------------------
module fpa_cfg
  import fpa_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     page_class,
  output region_t                  region
);

  logic [ADDR_BITS-1:0]  small_base;
  logic [COUNT_BITS-1:0] small_pages;
  logic [ADDR_BITS-1:0]  large_base;
  logic [COUNT_BITS-1:0] large_pages;
  logic [ADDR_BITS-1:0]  sel_base;
  logic [COUNT_BITS-1:0] sel_pages;

  always_ff @(posedge clk) begin
    if (rst) begin
      small_base  <= '0;
      small_pages <= '0;
      large_base  <= '0;
      large_pages <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SMALL_BASE:  small_base  <= cfg_data[ADDR_BITS-1:0];
        REG_SMALL_PAGES: small_pages <= cfg_data[COUNT_BITS-1:0];
        REG_LARGE_BASE:  large_base  <= cfg_data[ADDR_BITS-1:0];
        REG_LARGE_PAGES: large_pages <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sel_base  = page_class ? large_base : small_base;
    sel_pages = page_class ? large_pages : small_pages;
    // Bases are rounded down to page alignment; counts saturate at the table size.
    region.base  = sel_base & ~low_mask(page_class);
    region.pages = (sel_pages > COUNT_BITS'(MAX_PAGES)) ? COUNT_BITS'(MAX_PAGES) : sel_pages;
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free page list allocator testbench
// Sends get, put, init and unused words to both free lists under several region
// settings, and checks every result word against a predictor of both lists.
// ----------------------------------------------------------------------------
module tb_top
  import fpa_pkg::*;
;

  localparam logic [1:0] FUNC_NONE         = 2'd3;
  localparam logic       CLS_SMALL         = 1'b0;
  localparam logic       CLS_LARGE         = 1'b1;
  localparam int         WATCHDOG_LIMIT    = 6000;
  localparam int         DRAIN_CYCLES      = 40;
  localparam int         REPORT_LIMIT      = 10;
  localparam int         HELD_POOL_MAX     = 64;
  localparam int         WORDS_PER_SETTING = 113;
  localparam logic [ADDR_BITS-1:0] ADDR_ONES = '1;

  logic                     clk;
  logic                     rst       = 1'b1;
  logic                     cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  in_t                      in_item   = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  out_t                     out_item;

  // Predicted state of both free lists and the region registers.
  logic [IDX_BITS-1:0]   next_tab   [2][MAX_PAGES];
  logic [IDX_BITS-1:0]   head_ptr   [2] = '{default: '0};
  logic [IDX_BITS-1:0]   tail_ptr   [2] = '{default: '0};
  logic [COUNT_BITS-1:0] page_count [2] = '{default: '0};
  logic [ADDR_BITS-1:0]  base_reg   [2] = '{default: '0};
  logic [COUNT_BITS-1:0] pages_reg  [2] = '{default: '0};

  out_t                 pending_results [$];
  out_t                 oldest_expected;
  logic [ADDR_BITS-1:0] small_held [$];
  logic [ADDR_BITS-1:0] large_held [$];

  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_request   = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  fifo_free_page_list_allocator_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int page_shift(input logic c);
    return c ? LARGE_PAGE_SHIFT : SMALL_PAGE_SHIFT;
  endfunction

  function automatic logic [ADDR_BITS-1:0] page_mask(input logic c);
    return (ADDR_BITS'(1) << page_shift(c)) - ADDR_BITS'(1);
  endfunction

  function automatic logic [ADDR_BITS-1:0] aligned_base(input logic c);
    return base_reg[c] & ~page_mask(c);
  endfunction

  function automatic logic [COUNT_BITS-1:0] clamped_pages(input logic c);
    return (pages_reg[c] > MAX_PAGES) ? COUNT_BITS'(MAX_PAGES) : pages_reg[c];
  endfunction

  function automatic void append_page(input logic c, input logic [IDX_BITS-1:0] idx);
    if (page_count[c] != 0) begin
      next_tab[c][tail_ptr[c]] = idx;
    end else begin
      head_ptr[c] = idx;
    end
    next_tab[c][idx] = '0;
    tail_ptr[c] = idx;
    page_count[c] = page_count[c] + 1'b1;
  endfunction

  // Applies one word to the predicted lists and returns the result it gives.
  function automatic out_t apply_list_op(input in_t w);
    out_t                  r;
    logic                  c;
    logic                  ok;
    int                    sh;
    logic [ADDR_BITS-1:0]  base;
    logic [ADDR_BITS-1:0]  offset;
    logic [COUNT_BITS-1:0] n;
    logic [IDX_BITS-1:0]   idx;
    c    = w.page_class;
    sh   = page_shift(c);
    base = aligned_base(c);
    n    = clamped_pages(c);
    r    = '0;
    case (w.func)
      FUNC_GET: begin
        if (page_count[c] == 0) begin
          r.status = ST_EMPTY;
        end else begin
          idx = head_ptr[c];
          head_ptr[c] = next_tab[c][idx];
          page_count[c] = page_count[c] - 1'b1;
          r.granted_addr = base + (ADDR_BITS'(idx) << sh);
          r.zero_fill = w.clear_request;
        end
      end
      FUNC_PUT: begin
        ok = ((w.free_addr & page_mask(c)) == 0) && (w.free_addr >= base);
        offset = (w.free_addr - base) >> sh;
        if (ok && offset >= ADDR_BITS'(n)) ok = 1'b0;
        if (ok && page_count[c] >= MAX_PAGES) ok = 1'b0;
        if (ok) begin
          append_page(c, IDX_BITS'(offset));
        end else begin
          r.status = ST_BAD;
        end
      end
      FUNC_INIT: begin
        head_ptr[c] = '0;
        tail_ptr[c] = '0;
        page_count[c] = '0;
        for (int i = 0; i < n; i++) append_page(c, IDX_BITS'(i));
      end
      default: ;
    endcase
    r.free_count = page_count[c];
    return r;
  endfunction

  function automatic logic [ADDR_BITS-1:0] random_addr();
    return ADDR_BITS'({$urandom(), $urandom()});
  endfunction

  // Address for a put: mostly pages handed out earlier or inside the region,
  // the rest misaligned, below the base, at the region end or anywhere.
  function automatic logic [ADDR_BITS-1:0] pick_free_addr(input logic c);
    logic [ADDR_BITS-1:0]  a;
    logic [ADDR_BITS-1:0]  base;
    logic [COUNT_BITS-1:0] n;
    int                    sh;
    int                    roll;
    int                    k;
    sh   = page_shift(c);
    base = aligned_base(c);
    n    = clamped_pages(c);
    a    = random_addr();
    roll = $urandom_range(99);
    if (roll < 55 && c == CLS_SMALL && small_held.size() != 0) begin
      k = $urandom_range(small_held.size() - 1);
      a = small_held[k];
      small_held.delete(k);
    end else if (roll < 55 && c == CLS_LARGE && large_held.size() != 0) begin
      k = $urandom_range(large_held.size() - 1);
      a = large_held[k];
      large_held.delete(k);
    end else if (roll < 72 && n != 0) begin
      a = base + (ADDR_BITS'($urandom_range(n - 1)) << sh);
    end else if (roll < 80) begin
      a = base + (ADDR_BITS'($urandom_range(n)) << sh)
        + (ADDR_BITS'(1) << $urandom_range(sh - 1));
    end else if (roll < 86) begin
      a = base - (ADDR_BITS'($urandom_range(8, 1)) << sh);
    end else if (roll < 92) begin
      a = base + (ADDR_BITS'(n) << sh);
    end
    return a;
  endfunction

  function automatic in_t make_word(input logic [1:0] func, input logic c,
                                    input logic [ADDR_BITS-1:0] addr, input logic clr);
    in_t w;
    w.func          = func;
    w.page_class    = c;
    w.free_addr     = addr;
    w.clear_request = clr;
    return w;
  endfunction

  function automatic in_t random_word();
    in_t w;
    int  roll;
    roll            = $urandom_range(99);
    w.page_class    = 1'($urandom_range(1));
    w.clear_request = 1'($urandom_range(1));
    w.free_addr     = random_addr();
    if (roll < 46) begin
      w.func = FUNC_GET;
    end else if (roll < 93) begin
      w.func = FUNC_PUT;
      w.free_addr = pick_free_addr(w.page_class);
    end else if (roll < 97) begin
      w.func = FUNC_INIT;
    end else begin
      w.func = FUNC_NONE;
    end
    return w;
  endfunction

  function automatic logic [ADDR_BITS-1:0] pick_base();
    case ($urandom_range(3))
      0:       return '0;
      1:       return ADDR_ONES;
      2:       return random_addr();
      default: return ADDR_BITS'($urandom_range(255)) << LARGE_PAGE_SHIFT;
    endcase
  endfunction

  function automatic logic [COUNT_BITS-1:0] pick_pages();
    case ($urandom_range(9))
      0:       return '0;
      1:       return COUNT_BITS'(1);
      2:       return COUNT_BITS'(MAX_PAGES);
      3:       return '1;
      default: return COUNT_BITS'($urandom_range(48, 2));
    endcase
  endfunction

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Offers one word and records its predicted result once it is accepted.
  task automatic send_word(input in_t w);
    out_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= w;
    do @(posedge clk); while (!in_ready);
    r = apply_list_op(w);
    pending_results.push_back(r);
    if (w.func == FUNC_GET && r.status == ST_OK) begin
      if (w.page_class == CLS_LARGE) large_held.push_back(r.granted_addr);
      else small_held.push_back(r.granted_addr);
    end
    if (small_held.size() > HELD_POOL_MAX) void'(small_held.pop_front());
    if (large_held.size() > HELD_POOL_MAX) void'(large_held.pop_front());
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_SMALL_BASE:  base_reg[CLS_SMALL]  = data;
      REG_SMALL_PAGES: pages_reg[CLS_SMALL] = data[COUNT_BITS-1:0];
      REG_LARGE_BASE:  base_reg[CLS_LARGE]  = data;
      REG_LARGE_PAGES: pages_reg[CLS_LARGE] = data[COUNT_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regions(input logic [ADDR_BITS-1:0] small_base,
                                 input logic [COUNT_BITS-1:0] small_pages,
                                 input logic [ADDR_BITS-1:0] large_base,
                                 input logic [COUNT_BITS-1:0] large_pages);
    wait_idle();
    write_reg(REG_SMALL_BASE, small_base);
    write_reg(REG_SMALL_PAGES, CFG_DATA_BITS'(small_pages));
    write_reg(REG_LARGE_BASE, large_base);
    write_reg(REG_LARGE_PAGES, CFG_DATA_BITS'(large_pages));
    cfg_write <= 1'b0;
  endtask

  // With all regions empty, gets find nothing, puts are rejected, and init and unused words give empty results.
  task automatic test_empty_after_reset();
    send_word(make_word(FUNC_GET, CLS_SMALL, '0, 1'b1));
    send_word(make_word(FUNC_GET, CLS_LARGE, '0, 1'b0));
    send_word(make_word(FUNC_PUT, CLS_SMALL, '0, 1'b0));
    send_word(make_word(FUNC_INIT, CLS_SMALL, ADDR_ONES, 1'b1));
    send_word(make_word(FUNC_NONE, CLS_SMALL, '0, 1'b0));
    send_word(make_word(FUNC_NONE, CLS_LARGE, ADDR_ONES, 1'b1));
  endtask

  // Both lists filled to the maximum, which also writes every next pointer.
  // Unaligned bases are rounded down and the megapage addresses wrap.
  task automatic test_full_lists();
    logic [ADDR_BITS-1:0] sb;
    program_regions(39'h00_1234_5678, '1, ADDR_ONES, COUNT_BITS'(MAX_PAGES));
    sb = aligned_base(CLS_SMALL);
    send_word(make_word(FUNC_INIT, CLS_SMALL, '0, 1'b0));
    send_word(make_word(FUNC_INIT, CLS_LARGE, '0, 1'b0));
    send_word(make_word(FUNC_PUT, CLS_SMALL, sb, 1'b0));
    send_word(make_word(FUNC_GET, CLS_SMALL, '0, 1'b1));
    send_word(make_word(FUNC_GET, CLS_LARGE, '0, 1'b0));
    send_word(make_word(FUNC_GET, CLS_LARGE, ADDR_ONES, 1'b1));
    send_word(make_word(FUNC_PUT, CLS_SMALL,
                        sb + (ADDR_BITS'(1) << (SMALL_PAGE_SHIFT - 1)), 1'b0));
    send_word(make_word(FUNC_PUT, CLS_SMALL, sb - (ADDR_BITS'(1) << SMALL_PAGE_SHIFT), 1'b0));
    send_word(make_word(FUNC_PUT, CLS_SMALL,
                        sb + (ADDR_BITS'(MAX_PAGES) << SMALL_PAGE_SHIFT), 1'b1));
    send_word(make_word(FUNC_PUT, CLS_SMALL, sb, 1'b1));
    send_word(make_word(FUNC_PUT, CLS_LARGE, ADDR_ONES, 1'b0));
  endtask

  // A region moved after its init, a page put back twice, and one-page lists.
  task automatic test_region_change();
    program_regions('0, COUNT_BITS'(4), '0, COUNT_BITS'(1));
    send_word(make_word(FUNC_GET, CLS_SMALL, '0, 1'b0));
    send_word(make_word(FUNC_INIT, CLS_SMALL, '0, 1'b0));
    send_word(make_word(FUNC_GET, CLS_SMALL, '0, 1'b1));
    send_word(make_word(FUNC_PUT, CLS_SMALL, '0, 1'b0));
    send_word(make_word(FUNC_PUT, CLS_SMALL, '0, 1'b1));
    send_word(make_word(FUNC_INIT, CLS_LARGE, '0, 1'b0));
    send_word(make_word(FUNC_GET, CLS_LARGE, '0, 1'b1));
    send_word(make_word(FUNC_GET, CLS_LARGE, '0, 1'b1));
    send_word(make_word(FUNC_PUT, CLS_LARGE, '0, 1'b0));
    send_word(make_word(FUNC_PUT, CLS_LARGE, ADDR_BITS'(1) << LARGE_PAGE_SHIFT, 1'b0));
  endtask

  // Random traffic over several region settings, each starting from fresh lists.
  task automatic test_traffic(input int send_pct, input int recv_pct);
    set_idling(send_pct, recv_pct);
    repeat (4) begin
      program_regions(pick_base(), pick_pages(), pick_base(), pick_pages());
      send_word(make_word(FUNC_INIT, CLS_SMALL, random_addr(), 1'($urandom_range(1))));
      send_word(make_word(FUNC_INIT, CLS_LARGE, random_addr(), 1'($urandom_range(1))));
      repeat (WORDS_PER_SETTING) send_word(random_word());
    end
  endtask

  // The result side stops for a long stretch so the block must stall its input.
  task automatic test_backpressure();
    set_idling(0, 0);
    hold_request = 300;
    repeat (40) send_word(random_word());
  endtask

  // Result side: checks each accepted word and drives out_ready.
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result word: addr %h status %0d count %0d zero_fill %0b",
                   out_item.granted_addr, out_item.status, out_item.free_count,
                   out_item.zero_fill);
      end else begin
        oldest_expected = pending_results.pop_front();
        if (out_item.granted_addr !== oldest_expected.granted_addr ||
            out_item.status !== oldest_expected.status ||
            out_item.free_count !== oldest_expected.free_count ||
            out_item.zero_fill !== oldest_expected.zero_fill) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("result mismatch: expected addr %h status %0d count %0d zf %0b, got %s",
                     oldest_expected.granted_addr, oldest_expected.status,
                     oldest_expected.free_count, oldest_expected.zero_fill,
                     $sformatf("addr %h status %0d count %0d zf %0b",
                               out_item.granted_addr, out_item.status,
                               out_item.free_count, out_item.zero_fill));
        end
      end
    end
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Ends the run when no word moves on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    set_idling(34, 54);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_empty_after_reset();
    test_full_lists();
    test_region_change();
    test_traffic(34, 54);
    test_traffic(54, 34);
    test_backpressure();
    test_traffic(0, 0);
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
